[rtl/core/outlier_filtered_mean_direction_assert.svh]
// Assertion macros shared by the RTL of the mean direction block.
`ifndef OUTLIER_FILTERED_MEAN_DIRECTION_ASSERT_SVH
`define OUTLIER_FILTERED_MEAN_DIRECTION_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define OFMD_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("ofmd: invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define OFMD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ofmd: same-cycle implication violated");

// A consequence that must hold in the cycle after its cause.
`define OFMD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ofmd: next-cycle implication violated");

`endif

[rtl/core/ofmd_pkg.sv]
`default_nettype none

package ofmd_pkg;

    // Storage and field widths.
    localparam int MAX_SAMPLES   = 256;
    localparam int FRACTION_BITS = 14;
    localparam int ADDR_W        = $clog2(MAX_SAMPLES);
    localparam int DIR_W         = 16;
    localparam int CNT_W         = 9;
    localparam int CFG_W         = 16;
    localparam int SUM_W         = 25;
    localparam int MAG_W         = SUM_W;
    localparam int DOT_W         = 32;

    // Normalisation window: the largest scaled magnitude lies in [2^20, 2^21).
    localparam int WIN_LSB  = 20;
    localparam int SCALED_W = WIN_LSB + 1;
    localparam int SQ_W     = 2 * SCALED_W + 2;
    localparam int ROOT_W   = SCALED_W + 1;
    localparam int NUM_W    = SCALED_W + FRACTION_BITS + 1;
    localparam int QUO_W    = 16;
    localparam int REM_W    = ROOT_W + 1;
    localparam int DCNT_W   = $clog2(QUO_W);

    localparam logic [DIR_W-1:0] ONE_Q = DIR_W'(1 << FRACTION_BITS);

    // Register indexes of the configuration port.
    localparam logic REG_COS_THRESHOLD = 1'b0;
    localparam logic REG_MIN_COUNT     = 1'b1;

    typedef enum logic [1:0] {
        STAT_FILTERED   = 2'd0,
        STAT_UNFILTERED = 2'd1,
        STAT_ZERO_SUM   = 2'd2,
        STAT_TOO_FEW    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_N_ABS,
        ST_N_SHIFT,
        ST_N_SQ,
        ST_N_SQRT,
        ST_N_DIV_INIT,
        ST_N_DIV,
        ST_N_DONE,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[rtl/core/outlier_filtered_mean_direction.sv]
// Outlier-filtered mean direction of a set of unit bearing vectors (Q1.14).
// Input channel (s_valid/s_ready): one word per bearing; s_carries_sample marks a
// word that holds a sample, s_last closes the set. Words are taken only while idle.
// Result channel (m_valid/m_ready): one word per closing input word, giving the
// direction, kept and total counts, status and the overflow flag.
// Samples live in a buffer of MAX_SAMPLES entries with one write and one registered read.
// After a closing word the block is busy. A set with too few samples goes straight
// to the result, and a zero sum ends the work after the first normalisation. Each
// normalisation runs a shift search, three squares, a 22-step square root and three
// 16-step divisions; one gives the mean, then a second pass reads each stored
// sample (buffer read plus three dot-product multiplies on one multiplier), then a
// second normalisation unless none was kept; then the word goes to the output register.
// The finished word sits in an output register; the next set is loaded while it
// waits, and a further result waits in the sequencer until the register is free.
// Reset (aresetn, synchronous, active low) empties the set, drops any result and
// restores the thresholds; the buffer itself is not cleared.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr at once.
`default_nettype none

`include "outlier_filtered_mean_direction_assert.svh"

module outlier_filtered_mean_direction (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [ofmd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ofmd_pkg::DIR_W-1:0]   s_dir_x,
    input  logic signed [ofmd_pkg::DIR_W-1:0]   s_dir_y,
    input  logic signed [ofmd_pkg::DIR_W-1:0]   s_dir_z,
    input  logic                                s_carries_sample,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ofmd_pkg::DIR_W-1:0]   m_mean_x,
    output logic signed [ofmd_pkg::DIR_W-1:0]   m_mean_y,
    output logic signed [ofmd_pkg::DIR_W-1:0]   m_mean_z,
    output logic [ofmd_pkg::CNT_W-1:0]          m_kept_count,
    output logic [ofmd_pkg::CNT_W-1:0]          m_total_count,
    output logic [1:0]                          m_status,
    output logic                                m_overflowed
);
    import ofmd_pkg::*;

    state_t state_reg, state_next;

    logic signed [DIR_W-1:0] cos_threshold_reg;
    logic [CNT_W-1:0]        min_count_reg;

    // Sample buffer and running set state.
    logic [3*DIR_W-1:0]      sample_mem [MAX_SAMPLES];
    logic [3*DIR_W-1:0]      rd_data_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0]        sample_count_reg;
    logic                    dropped_reg;

    // Normalisation unit.
    logic                    pass_reg;
    logic                    zero_reg;
    logic                    neg_reg [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic [MAG_W-1:0]        max_reg;
    logic [1:0]              sq_idx_reg;
    logic [SQ_W-1:0]         rad_reg;
    logic [SQ_W-1:0]         root_reg;
    logic [SQ_W-1:0]         bit_reg;
    logic [1:0]              div_idx_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        num_lo_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic signed [DIR_W-1:0] q_reg [3];

    // Second pass over the buffer.
    logic signed [DIR_W-1:0] mean_reg [3];
    logic [CNT_W-1:0]        scan_idx_reg;
    logic [2:0]              phase_reg;
    logic signed [DOT_W-1:0] prod_reg;
    logic signed [DOT_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] fs_reg [3];
    logic [CNT_W-1:0]        kept_reg;

    // Result staging and output register.
    logic signed [DIR_W-1:0] res_reg [3];
    logic [CNT_W-1:0]        res_kept_reg;
    status_t                 res_status_reg;
    logic                    m_valid_reg;
    logic signed [DIR_W-1:0] m_mean_reg [3];
    logic [CNT_W-1:0]        m_kept_reg;
    logic [CNT_W-1:0]        m_total_reg;
    status_t                 m_status_reg;
    logic                    m_over_reg;

    // Combinational helpers.
    logic                    in_accept;
    logic                    out_load;
    logic                    has_room;
    logic signed [SUM_W-1:0] src [3];
    logic [MAG_W-1:0]        abs_val [3];
    logic [MAG_W-1:0]        abs_max;
    logic [SCALED_W-1:0]     sq_op;
    logic [2*SCALED_W-1:0]   sq_prod;
    logic [SQ_W-1:0]         trial_sum;
    logic [NUM_W-1:0]        div_num;
    logic [REM_W+1:0]        div_diff;
    logic [QUO_W-1:0]        quo_new;
    logic [REM_W-1:0]        rem_new;
    logic [QUO_W-1:0]        quo_cap;
    logic signed [DIR_W-1:0] q_signed;
    logic signed [DIR_W-1:0] rd_comp [3];
    logic signed [DIR_W-1:0] mul_a;
    logic signed [DIR_W-1:0] mul_b;
    logic signed [DOT_W-1:0] dot;
    logic signed [DOT_W-1:0] thr;
    logic                    keep;
    logic [CNT_W-1:0]        kept_new;
    logic                    scan_end;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign has_room  = (sample_count_reg < CNT_W'(MAX_SAMPLES));

    // Absolute values and their maximum for the vector being normalised.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            src[i]     = pass_reg ? fs_reg[i] : sum_reg[i];
            abs_val[i] = src[i][SUM_W-1] ? unsigned'(-src[i]) : unsigned'(src[i]);
        end
        abs_max = abs_val[0];
        if (abs_val[1] > abs_max) begin
            abs_max = abs_val[1];
        end
        if (abs_val[2] > abs_max) begin
            abs_max = abs_val[2];
        end
    end

    // Squares, square root step and division step.
    assign sq_op     = mag_reg[sq_idx_reg][SCALED_W-1:0];
    assign sq_prod   = sq_op * sq_op;
    assign trial_sum = root_reg + bit_reg;
    assign div_num   = {mag_reg[div_idx_reg][SCALED_W-1:0], {FRACTION_BITS{1'b0}}}
                       + NUM_W'(root_reg[ROOT_W-1:1]);
    assign div_diff  = {1'b0, rem_reg, num_lo_reg[QUO_W-1]}
                       - {{(REM_W+2-ROOT_W){1'b0}}, root_reg[ROOT_W-1:0]};

    always_comb begin
        if (!div_diff[REM_W+1]) begin
            rem_new = div_diff[REM_W-1:0];
            quo_new = {quo_reg[QUO_W-2:0], 1'b1};
        end else begin
            rem_new = {rem_reg[REM_W-2:0], num_lo_reg[QUO_W-1]};
            quo_new = {quo_reg[QUO_W-2:0], 1'b0};
        end
        quo_cap  = (quo_new > ONE_Q) ? ONE_Q : quo_new;
        q_signed = neg_reg[div_idx_reg] ? signed'(-quo_cap) : signed'(quo_cap);
    end

    // Dot product of a stored sample with the mean, one component a cycle.
    always_comb begin
        rd_comp[0] = signed'(rd_data_reg[DIR_W-1:0]);
        rd_comp[1] = signed'(rd_data_reg[2*DIR_W-1:DIR_W]);
        rd_comp[2] = signed'(rd_data_reg[3*DIR_W-1:2*DIR_W]);
        case (phase_reg)
            3'd2: begin
                mul_a = rd_comp[1];
                mul_b = mean_reg[1];
            end
            3'd3: begin
                mul_a = rd_comp[2];
                mul_b = mean_reg[2];
            end
            default: begin
                mul_a = rd_comp[0];
                mul_b = mean_reg[0];
            end
        endcase
        dot      = acc_reg + prod_reg;
        thr      = DOT_W'(cos_threshold_reg) <<< FRACTION_BITS;
        keep     = (dot >= thr);
        kept_new = kept_reg + CNT_W'(keep);
        scan_end = ((scan_idx_reg + 1'b1) == sample_count_reg);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (sample_count_reg < min_count_reg) ? ST_OUT : ST_N_ABS;
            end
            ST_N_ABS: begin
                state_next = ST_N_SHIFT;
            end
            ST_N_SHIFT: begin
                if (max_reg == '0) begin
                    state_next = ST_N_DONE;
                end else if (max_reg[MAG_W-1:SCALED_W] == '0 && max_reg[WIN_LSB]) begin
                    state_next = ST_N_SQ;
                end
            end
            ST_N_SQ: begin
                if (sq_idx_reg == 2'd2) begin
                    state_next = ST_N_SQRT;
                end
            end
            ST_N_SQRT: begin
                if (bit_reg == '0) begin
                    state_next = ST_N_DIV_INIT;
                end
            end
            ST_N_DIV_INIT: begin
                state_next = ST_N_DIV;
            end
            ST_N_DIV: begin
                if (div_cnt_reg == DCNT_W'(QUO_W - 1)) begin
                    state_next = (div_idx_reg == 2'd2) ? ST_N_DONE : ST_N_DIV_INIT;
                end
            end
            ST_N_DONE: begin
                state_next = (!pass_reg && !zero_reg) ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                if (phase_reg == 3'd4 && scan_end) begin
                    state_next = (kept_new == '0) ? ST_OUT : ST_N_ABS;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_threshold_reg <= DIR_W'(14189);
            min_count_reg     <= CNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COS_THRESHOLD: cos_threshold_reg <= signed'(cfg_wdata[DIR_W-1:0]);
                REG_MIN_COUNT:     min_count_reg     <= cfg_wdata[CNT_W-1:0];
                default:           min_count_reg     <= min_count_reg;
            endcase
        end
    end

    // Sample buffer: written while loading, read every cycle at the scan index.
    always_ff @(posedge aclk) begin
        if (in_accept && s_carries_sample && has_room) begin
            sample_mem[sample_count_reg[ADDR_W-1:0]] <= {s_dir_z, s_dir_y, s_dir_x};
        end
        rd_data_reg <= sample_mem[scan_idx_reg[ADDR_W-1:0]];
    end

    // Running sum, count and drop flag of the open set.
    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
            sample_count_reg <= '0;
            dropped_reg      <= 1'b0;
        end else if (in_accept && s_carries_sample) begin
            if (has_room) begin
                sum_reg[0]       <= sum_reg[0] + SUM_W'(s_dir_x);
                sum_reg[1]       <= sum_reg[1] + SUM_W'(s_dir_y);
                sum_reg[2]       <= sum_reg[2] + SUM_W'(s_dir_z);
                sample_count_reg <= sample_count_reg + 1'b1;
            end else begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // Sequencer datapath: normalisation, second pass and result staging.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CHECK: begin
                pass_reg <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    res_reg[i] <= '0;
                end
                res_kept_reg   <= '0;
                res_status_reg <= STAT_TOO_FEW;
            end
            ST_N_ABS: begin
                zero_reg <= 1'b0;
                max_reg  <= abs_max;
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= abs_val[i];
                    neg_reg[i] <= src[i][SUM_W-1];
                end
            end
            ST_N_SHIFT: begin
                sq_idx_reg <= 2'd0;
                rad_reg    <= '0;
                if (max_reg == '0) begin
                    zero_reg <= 1'b1;
                end else if (max_reg[MAG_W-1:SCALED_W] != '0) begin
                    max_reg <= max_reg >> 1;
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end else if (!max_reg[WIN_LSB]) begin
                    max_reg <= max_reg << 1;
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            ST_N_SQ: begin
                rad_reg    <= rad_reg + SQ_W'(sq_prod);
                sq_idx_reg <= sq_idx_reg + 1'b1;
                root_reg   <= '0;
                bit_reg    <= SQ_W'(1) << (SQ_W - 2);
            end
            ST_N_SQRT: begin
                div_idx_reg <= 2'd0;
                if (bit_reg != '0) begin
                    if (rad_reg >= trial_sum) begin
                        rad_reg  <= rad_reg - trial_sum;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_N_DIV_INIT: begin
                rem_reg     <= REM_W'(div_num[NUM_W-1:QUO_W]);
                num_lo_reg  <= div_num[QUO_W-1:0];
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_N_DIV: begin
                rem_reg     <= rem_new;
                quo_reg     <= quo_new;
                num_lo_reg  <= num_lo_reg << 1;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(QUO_W - 1)) begin
                    q_reg[div_idx_reg] <= q_signed;
                    div_idx_reg        <= div_idx_reg + 1'b1;
                end
            end
            ST_N_DONE: begin
                scan_idx_reg <= '0;
                phase_reg    <= 3'd0;
                if (zero_reg) begin
                    res_reg[0]     <= signed'(ONE_Q);
                    res_reg[1]     <= '0;
                    res_reg[2]     <= '0;
                    res_kept_reg   <= pass_reg ? kept_reg : '0;
                    res_status_reg <= STAT_ZERO_SUM;
                end else if (pass_reg) begin
                    for (int i = 0; i < 3; i++) begin
                        res_reg[i] <= q_reg[i];
                    end
                    res_kept_reg   <= kept_reg;
                    res_status_reg <= STAT_FILTERED;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        mean_reg[i] <= q_reg[i];
                        fs_reg[i]   <= '0;
                    end
                    kept_reg <= '0;
                end
            end
            ST_SCAN: begin
                prod_reg <= mul_a * mul_b;
                case (phase_reg)
                    3'd2: begin
                        acc_reg   <= prod_reg;
                        phase_reg <= 3'd3;
                    end
                    3'd3: begin
                        acc_reg   <= acc_reg + prod_reg;
                        phase_reg <= 3'd4;
                    end
                    3'd4: begin
                        if (keep) begin
                            for (int i = 0; i < 3; i++) begin
                                fs_reg[i] <= fs_reg[i] + SUM_W'(rd_comp[i]);
                            end
                        end
                        kept_reg     <= kept_new;
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        phase_reg    <= 3'd0;
                        pass_reg     <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            res_reg[i] <= mean_reg[i];
                        end
                        res_kept_reg   <= '0;
                        res_status_reg <= STAT_UNFILTERED;
                    end
                    default: begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                endcase
            end
            default: begin
                pass_reg <= pass_reg;
            end
        endcase
    end

    // Output register: a finished word waits here for the receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                m_mean_reg[i] <= res_reg[i];
            end
            m_kept_reg   <= res_kept_reg;
            m_total_reg  <= sample_count_reg;
            m_status_reg <= res_status_reg;
            m_over_reg   <= dropped_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mean_x      = m_mean_reg[0];
    assign m_mean_y      = m_mean_reg[1];
    assign m_mean_z      = m_mean_reg[2];
    assign m_kept_count  = m_kept_reg;
    assign m_total_count = m_total_reg;
    assign m_status      = m_status_reg;
    assign m_overflowed  = m_over_reg;

    // Checks on the sequencer and the result.
    `OFMD_ASSERT_ALWAYS(a_count_bounded, aclk, aresetn, sample_count_reg <= CNT_W'(MAX_SAMPLES))
    `OFMD_ASSERT_NEXT(a_set_cleared, aclk, aresetn, out_load, sample_count_reg == '0)
    `OFMD_ASSERT_SAME(a_kept_le_total, aclk, aresetn, m_valid_reg, m_kept_reg <= m_total_reg)
    `OFMD_ASSERT_SAME(a_too_few_zero, aclk, aresetn, m_valid_reg && m_status_reg == STAT_TOO_FEW, m_mean_reg[0] == '0 && m_kept_reg == '0)

endmodule

`default_nettype wire
